FILE: src/slfa_pkg.sv
// Package for the slot free-list allocator.
// Holds the request and result item types, the controller state type and
// the command struct that joins controller and datapath. No dependencies.
package slfa_pkg;

  // Request codes carried in req_type.
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [3:0] slot_in;
  } req_t;

  typedef struct packed {
    logic       done_res;
    logic [3:0] slot_out;
    logic [4:0] live_count;
    logic       pool_full;
    logic       pool_empty;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } ctl_state_t;

  typedef struct packed {
    logic latch;   // capture the request
    logic lookup;  // read the head link and the slot's in-use bit
    logic update;  // apply the request and load the result
  } cmd_t;

endpackage

FILE: src/slfa_ctrl.sv
// Controller state machine of the slot free-list allocator.
// Depends on slfa_pkg for the state enum and the command struct.
module slfa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output slfa_pkg::cmd_t cmd
);
  import slfa_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy       = 1'b1;
    cmd.latch  = 1'b0;
    cmd.lookup = 1'b0;
    cmd.update = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

FILE: src/slfa_dpath.sv
// Datapath of the slot free-list allocator: link memory, in-use bits,
// free-list head, live count and the result register.
// Depends on slfa_pkg for the item types and the command struct.
module slfa_dpath #(
  parameter int SLOT_COUNT = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  slfa_pkg::cmd_t cmd,
  input  slfa_pkg::req_t in_req,
  output logic           out_valid,
  output slfa_pkg::res_t out_res
);
  import slfa_pkg::*;

  localparam int IW = $clog2(SLOT_COUNT);      // slot index width
  localparam int LW = $clog2(SLOT_COUNT + 1);  // link, head and count width
  localparam int XW = (LW > 4) ? LW : 4;       // common compare width
  localparam int OW = (LW > 5) ? LW : 5;       // count width before masking

  // Link memory; an entry not written since reset reads as its index plus one.
  logic [LW-1:0]         link_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] link_vld_r;
  logic [SLOT_COUNT-1:0] in_use_r;

  logic [LW-1:0] head_r;
  logic [LW-1:0] count_r;
  req_t          req_r;
  logic [LW-1:0] rd_link_r;
  logic          rd_vld_r;
  logic          used_bit_r;
  logic          out_valid_r;
  res_t          out_res_r;

  logic [XW-1:0] slot_x;
  logic [XW-1:0] head_x;
  logic [IW-1:0] slot_idx;
  logic [IW-1:0] head_idx;
  logic          slot_ok;
  logic          alloc_ok;
  logic          rel_ok;
  logic [LW-1:0] link_val;
  logic [LW-1:0] count_nxt;
  logic [XW-1:0] grant_x;
  logic [OW-1:0] count_o;

  assign slot_x   = XW'(req_r.slot_in);
  assign head_x   = XW'(head_r);
  assign slot_idx = slot_x[IW-1:0];
  assign head_idx = head_r[IW-1:0];
  assign slot_ok  = slot_x < XW'(SLOT_COUNT);

  assign alloc_ok = (req_r.req_type == REQ_ALLOC) &&
                    (count_r < LW'(SLOT_COUNT)) && (head_x < XW'(SLOT_COUNT));
  assign rel_ok   = (req_r.req_type == REQ_RELEASE) && slot_ok && used_bit_r;
  assign link_val = rd_vld_r ? rd_link_r : head_r + LW'(1);

  always_comb begin
    count_nxt = count_r;
    grant_x   = '0;
    if (alloc_ok) begin
      count_nxt = count_r + LW'(1);
      grant_x   = head_x;
    end else if (rel_ok) begin
      if (count_r != '0) begin
        count_nxt = count_r - LW'(1);
      end
      grant_x = slot_x;
    end
  end

  assign count_o = OW'(count_nxt);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= in_req;
    end
    if (cmd.lookup) begin
      rd_link_r  <= link_mem[head_idx];
      rd_vld_r   <= link_vld_r[head_idx];
      used_bit_r <= in_use_r[slot_idx];
    end
    if (cmd.update && rel_ok) begin
      link_mem[slot_idx] <= head_r;
    end
    if (cmd.update) begin
      out_res_r.done_res   <= alloc_ok || rel_ok;
      out_res_r.slot_out   <= grant_x[3:0];
      out_res_r.live_count <= count_o[4:0];
      out_res_r.pool_full  <= count_nxt == LW'(SLOT_COUNT);
      out_res_r.pool_empty <= count_nxt == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_vld_r  <= '0;
      in_use_r    <= '0;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.update;
      if (cmd.update) begin
        count_r <= count_nxt;
        if (alloc_ok) begin
          head_r             <= link_val;
          in_use_r[head_idx] <= 1'b1;
        end else if (rel_ok) begin
          head_r               <= slot_x[LW-1:0];
          in_use_r[slot_idx]   <= 1'b0;
          link_vld_r[slot_idx] <= 1'b1;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

FILE: src/slot_free_list_allocator_unit.sv
// Top level of the slot free-list allocator.
// Depends on slfa_pkg, slfa_ctrl and slfa_dpath.
//
//   channel   ports                     handshake
//   request   start, busy, in_req       taken when start is high and busy low
//   result    out_valid, out_res        one-cycle strobe, cannot be held off
//
// Each item passes through three steps: capture, link memory read, update. The
// result appears in the cycle after the update, when busy is already low,
// so a new item may be started in that same cycle. Reset is synchronous
// and clears the free list to slot 0 onward with no slot in use; no
// clearing pass is needed.
module slot_free_list_allocator_unit #(
  parameter int SLOT_COUNT = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  slfa_pkg::req_t in_req,
  output logic           out_valid,
  output slfa_pkg::res_t out_res
);
  import slfa_pkg::*;

  cmd_t cmd;

  slfa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  slfa_dpath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule
